### sv/tq_pkg.sv
package tq_pkg;

  localparam int unsigned MAX_POP = 16;
  localparam int unsigned POP_CNT_W = $clog2(MAX_POP + 1);

  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_DUE      = 2'd2;
  localparam logic [1:0] KIND_NONE_DUE = 2'd3;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [31:0]        due_time;
    logic [7:0]         action;
    logic               has_arg;
    logic signed [31:0] arg;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         action;
    logic               has_arg;
    logic signed [31:0] arg;
    logic               last;
  } out_item_t;

endpackage

### sv/tq_in_if.sv
interface tq_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [31:0]        time_value;
  logic [7:0]         action_code;
  logic               has_argument;
  logic signed [31:0] argument;

  modport source (
    output valid, func, time_value, action_code, has_argument, argument,
    input  ready
  );
  modport sink (
    input  valid, func, time_value, action_code, has_argument, argument,
    output ready
  );
endinterface

### sv/tq_out_if.sv
interface tq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         out_action;
  logic               out_has_argument;
  logic signed [31:0] out_argument;
  logic               last;

  modport source (
    output valid, kind, out_action, out_has_argument, out_argument, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_action, out_has_argument, out_argument, last,
    output ready
  );
endinterface

### sv/tq_cell.sv
module tq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tq_pkg::cell_ctl_t ctl,
  input  tq_pkg::entry_t    new_entry,
  input  tq_pkg::entry_t    left_entry,
  input  logic              left_valid,
  input  tq_pkg::entry_t    right_entry,
  input  logic              right_valid,
  input  logic              shift_in,
  output tq_pkg::entry_t    entry,
  output logic              valid,
  output logic              flag,
  output logic              due
);

  tq_pkg::entry_t entry_r, entry_nxt;
  logic           valid_r, valid_nxt;

  // insert position: the head takes strictly earlier times, the rest equal or earlier
  always_comb begin
    if (!valid_r) begin
      flag = 1'b1;
    end else if (IS_HEAD) begin
      flag = new_entry.due_time < entry_r.due_time;
    end else begin
      flag = entry_r.due_time >= new_entry.due_time;
    end
  end

  assign due = valid_r && (entry_r.due_time <= new_entry.due_time);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.insert) begin
      if (shift_in) begin
        entry_nxt = left_entry;
        valid_nxt = left_valid;
      end else if (flag) begin
        entry_nxt = new_entry;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

### sv/timed_action_queue_unit.sv
// Sorted queue of scheduled actions held in a row of cells, head in the first cell. On an
// add, every cell compares its due time with the new one in parallel and the row shifts
// right by one from the insert point in a single step; a full queue answers "rejected".
// A tick pops one due entry per cycle while the output is not stalled, since the head is
// emitted through the single output register while the row shifts left by one; a tick
// with nothing due answers "none due". At most 16 entries leave on one tick, the rest
// stay for the next. A new item is taken once the previous one has delivered its results.
module timed_action_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  tq_in_if.sink   in_ch,
  tq_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  tq_pkg::entry_t                   new_r, new_nxt;
  logic [tq_pkg::POP_CNT_W-1:0]     pop_cnt_r, pop_cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  tq_pkg::out_item_t                out_r, out_nxt;

  tq_pkg::cell_ctl_t                ctl;
  tq_pkg::entry_t                   entry_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]           valid_w;
  logic [QUEUE_DEPTH-1:0]           flag_w;
  logic [QUEUE_DEPTH-1:0]           due_w;
  logic [QUEUE_DEPTH-1:0]           shift_w;

  logic out_free;
  logic in_xfer;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign shift_w[gi] = 1'b0;
      end else if (gi == 1) begin : g_second
        assign shift_w[gi] = flag_w[0];
      end else begin : g_rest
        assign shift_w[gi] = flag_w[0] | flag_w[gi-1];
      end

      tq_cell #(
        .IS_HEAD (gi == 0)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .new_entry   (new_r),
        .left_entry  ((gi == 0) ? new_r : entry_w[(gi == 0) ? 0 : gi-1]),
        .left_valid  ((gi == 0) ? 1'b0 : valid_w[(gi == 0) ? 0 : gi-1]),
        .right_entry ((gi == QUEUE_DEPTH-1) ? entry_w[gi]
                      : entry_w[(gi == QUEUE_DEPTH-1) ? gi : gi+1]),
        .right_valid ((gi == QUEUE_DEPTH-1) ? 1'b0
                      : valid_w[(gi == QUEUE_DEPTH-1) ? gi : gi+1]),
        .shift_in    (shift_w[gi]),
        .entry       (entry_w[gi]),
        .valid       (valid_w[gi]),
        .flag        (flag_w[gi]),
        .due         (due_w[gi])
      );
    end
  endgenerate

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    new_nxt       = new_r;
    pop_cnt_nxt   = pop_cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ctl           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          new_nxt.due_time = in_ch.time_value;
          new_nxt.action   = in_ch.action_code;
          new_nxt.has_arg  = in_ch.has_argument;
          new_nxt.arg      = in_ch.has_argument ? in_ch.argument : 32'sd0;
          pop_cnt_nxt      = '0;
          state_nxt        = (in_ch.func == tq_pkg::FUNC_TICK) ? S_TICK : S_ADD;
        end
      end
      S_ADD: begin
        out_nxt       = '0;
        out_nxt.last  = 1'b1;
        out_valid_nxt = 1'b1;
        if (valid_w[QUEUE_DEPTH-1]) begin
          out_nxt.kind = tq_pkg::KIND_ADD_FULL;
        end else begin
          ctl.insert   = 1'b1;
          out_nxt.kind = tq_pkg::KIND_ADD_OK;
        end
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (due_w[0]) begin
            ctl.pop         = 1'b1;
            out_nxt.kind    = tq_pkg::KIND_DUE;
            out_nxt.action  = entry_w[0].action;
            out_nxt.has_arg = entry_w[0].has_arg;
            out_nxt.arg     = entry_w[0].arg;
            out_nxt.last    = !due_w[1] ||
                              (pop_cnt_r == tq_pkg::POP_CNT_W'(tq_pkg::MAX_POP - 1));
            pop_cnt_nxt     = pop_cnt_r + 1'b1;
            if (out_nxt.last) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_nxt      = '0;
            out_nxt.kind = tq_pkg::KIND_NONE_DUE;
            out_nxt.last = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    new_r <= new_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pop_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pop_cnt_r   <= pop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = out_r.kind;
  assign out_ch.out_action       = out_r.action;
  assign out_ch.out_has_argument = out_r.has_arg;
  assign out_ch.out_argument     = out_r.arg;
  assign out_ch.last             = out_r.last;

endmodule

### sv/tq_checker.sv
module tq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_func,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic [7:0]         out_action,
  input logic               out_has_argument,
  input logic signed [31:0] out_argument,
  input logic               out_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  a_add_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == tq_pkg::FUNC_ADD) |=> ##1
      out_valid && out_last &&
      ((out_kind == tq_pkg::KIND_ADD_OK) || (out_kind == tq_pkg::KIND_ADD_FULL)))
    else $error("add not answered in time");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != tq_pkg::KIND_DUE) |->
      out_last && (out_action == 8'd0) && !out_has_argument && (out_argument == 32'sd0))
    else $error("non-due result malformed");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind timed_action_queue_unit tq_checker u_tq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_func          (in_ch.func),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_action       (out_ch.out_action),
  .out_has_argument (out_ch.out_has_argument),
  .out_argument     (out_ch.out_argument),
  .out_last         (out_ch.last)
);

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DEPTH = 16;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 24;
  localparam logic [7:0] STALL_MASK = 8'b1011_0010;

  typedef enum int {RDY_OPEN, RDY_HALF, RDY_SPARSE, RDY_MASK} rdy_mode_e;

  logic clk;
  logic rst_n;

  tq_in_if in_bus ();
  tq_out_if out_bus ();

  timed_action_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // shadow of the schedule, head at index 0
  logic [31:0]        sched_time [DEPTH];
  logic [7:0]         sched_action [DEPTH];
  logic               sched_has_arg [DEPTH];
  logic signed [31:0] sched_arg [DEPTH];
  int unsigned        sched_count;

  tq_pkg::out_item_t pending_results[$];

  int errors;
  int burst_left;
  int stall_tick;
  int idle_cycles;
  int n_items, n_added, n_rejected, n_popped, n_empty_ticks;
  logic [31:0] now_t;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    errors++;
    $display("mismatch on %s: expected %0h, got %0h at %0t", what, want_v, got_v, $realtime);
  endtask

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] act,
                                      input logic has, input logic signed [31:0] arg,
                                      input logic last);
    tq_pkg::out_item_t res;
    res = '0;
    res.kind = kind;
    res.action = act;
    res.has_arg = has;
    res.arg = arg;
    res.last = last;
    pending_results.push_back(res);
  endfunction

  function automatic void schedule_outcome(input logic func, input logic [31:0] t,
                                           input logic [7:0] act, input logic has,
                                           input logic signed [31:0] arg);
    int unsigned pos;
    int unsigned n;
    n_items++;
    if (func == tq_pkg::FUNC_ADD) begin
      if (sched_count >= DEPTH) begin
        n_rejected++;
        push_result(tq_pkg::KIND_ADD_FULL, '0, 1'b0, '0, 1'b1);
        return;
      end
      if (sched_count == 0 || t < sched_time[0]) begin
        pos = 0;
      end else begin
        pos = 1;
        while (pos < sched_count && sched_time[pos] < t) pos++;
      end
      for (int i = sched_count; i > pos; i--) begin
        sched_time[i]    = sched_time[i-1];
        sched_action[i]  = sched_action[i-1];
        sched_has_arg[i] = sched_has_arg[i-1];
        sched_arg[i]     = sched_arg[i-1];
      end
      sched_time[pos]    = t;
      sched_action[pos]  = act;
      sched_has_arg[pos] = has;
      sched_arg[pos]     = has ? arg : '0;
      sched_count++;
      n_added++;
      push_result(tq_pkg::KIND_ADD_OK, '0, 1'b0, '0, 1'b1);
    end else begin
      n = 0;
      while (n < sched_count && n < tq_pkg::MAX_POP && sched_time[n] <= t) n++;
      if (n == 0) begin
        n_empty_ticks++;
        push_result(tq_pkg::KIND_NONE_DUE, '0, 1'b0, '0, 1'b1);
        return;
      end
      for (int i = 0; i < n; i++)
        push_result(tq_pkg::KIND_DUE, sched_action[i], sched_has_arg[i], sched_arg[i],
                    i + 1 == n);
      for (int i = n; i < sched_count; i++) begin
        sched_time[i-n]    = sched_time[i];
        sched_action[i-n]  = sched_action[i];
        sched_has_arg[i-n] = sched_has_arg[i];
        sched_arg[i-n]     = sched_arg[i];
      end
      sched_count -= n;
      n_popped += n;
    end
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic func, input logic [31:0] t, input logic [7:0] act,
                           input logic has, input logic signed [31:0] arg);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_bus.func = func;
    in_bus.time_value = t;
    in_bus.action_code = act;
    in_bus.has_argument = has;
    in_bus.argument = arg;
    in_bus.valid = 1'b1;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    schedule_outcome(func, t, act, has, arg);
    @(negedge clk);
  endtask

  task automatic add_action(input logic [31:0] t, input logic [7:0] act, input logic has,
                            input logic signed [31:0] arg);
    send_item(tq_pkg::FUNC_ADD, t, act, has, arg);
  endtask

  task automatic tick_at(input logic [31:0] t);
    send_item(tq_pkg::FUNC_TICK, t, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              $urandom);
  endtask

  task automatic wait_results_drained();
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_queue();
    tick_at(32'h0000_0000);
    wait_results_drained();
  endtask

  task automatic test_sorted_insert();
    add_action(32'd100, 8'h01, 1'b1, 32'sh0000_0001);
    add_action(32'd50, 8'hFF, 1'b1, 32'sh8000_0000);
    add_action(32'd50, 8'h02, 1'b0, 32'sh1234_5678);
    add_action(32'd100, 8'h00, 1'b1, 32'sh7FFF_FFFF);
    add_action(32'd0, 8'h03, 1'b1, 32'shFFFF_FFFF);
    add_action(32'hFFFF_FFFF, 8'h04, 1'b1, 32'sh5555_5555);
    tick_at(32'd49);
    tick_at(32'd100);
    wait_results_drained();
  endtask

  task automatic test_full_queue();
    int k;
    k = 0;
    while (sched_count < DEPTH) begin
      add_action(32'd1000 - 7 * k, 8'(k + 16), k[0], ~32'(k));
      k++;
    end
    add_action(32'd5, 8'hAA, 1'b1, 32'sh0BAD_CAFE);
    tick_at(32'hFFFF_FFFF);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int count);
    int add_pct;
    int sel;
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) add_pct = ($urandom_range(0, 2) == 0) ? 35 :
                                 ($urandom_range(0, 1) ? 60 : 85);
      if ($urandom_range(1, 100) <= add_pct) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0: t = $urandom;
          1: t = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          2: t = (sched_count != 0) ? sched_time[$urandom_range(0, sched_count - 1)]
                                    : now_t;
          default: t = now_t + $urandom_range(0, 300);
        endcase
        add_action(t, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        sel = $urandom_range(0, 11);
        case (sel)
          0: t = 32'hFFFF_FFFF;
          1: t = $urandom;
          2: t = now_t;
          default: begin
            now_t = now_t + $urandom_range(0, 150);
            t = now_t;
          end
        endcase
        tick_at(t);
      end
    end
    wait_results_drained();
  endtask

  always @(negedge clk) begin : ready_pattern
    rdy_mode_e mode;
    stall_tick++;
    mode = rdy_mode_e'((stall_tick / 173) % 4);
    case (mode)
      RDY_OPEN:   out_bus.ready = 1'b1;
      RDY_HALF:   out_bus.ready = 1'($urandom_range(0, 1));
      RDY_SPARSE: out_bus.ready = ($urandom_range(0, 3) == 0);
      default:    out_bus.ready = STALL_MASK[stall_tick % 8];
    endcase
  end

  always @(posedge clk) begin : result_check
    tq_pkg::out_item_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, 32'(out_bus.kind));
      end else begin
        want = pending_results.pop_front();
        if (out_bus.kind !== want.kind)
          report_mismatch("kind", 32'(want.kind), 32'(out_bus.kind));
        if (out_bus.out_action !== want.action)
          report_mismatch("out_action", 32'(want.action), 32'(out_bus.out_action));
        if (out_bus.out_has_argument !== want.has_arg)
          report_mismatch("out_has_argument", 32'(want.has_arg),
                          32'(out_bus.out_has_argument));
        if (out_bus.out_argument !== want.arg)
          report_mismatch("out_argument", want.arg, out_bus.out_argument);
        if (out_bus.last !== want.last)
          report_mismatch("last", 32'(want.last), 32'(out_bus.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.func = tq_pkg::FUNC_ADD;
    in_bus.time_value = '0;
    in_bus.action_code = '0;
    in_bus.has_argument = 1'b0;
    in_bus.argument = '0;
    out_bus.ready = 1'b0;
    sched_count = 0;
    now_t = $urandom;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_queue();
    test_sorted_insert();
    test_full_queue();
    test_random_traffic(140);
    test_random_traffic(140);
    test_random_traffic(145);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d adds taken, %0d adds refused on a full queue,",
             n_items, n_added, n_rejected);
    $display("%0d due actions popped and %0d ticks with nothing due, under stalls on both sides",
             n_popped, n_empty_ticks);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
